/* src/hbs_pkg.sv */
// Shared types and constants of the heightfield bilinear sampler.
`timescale 1ns / 1ps

package hbs_pkg;

    // sample store
    localparam int STORE_DEPTH = 65536;
    localparam int STORE_AW    = 16;
    localparam int SAMPLE_W    = 16;

    // default grid limits
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    // item selector
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_HEIGHT = 2'd1;
    localparam logic [1:0] FUNC_NORMAL = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // result kind
    localparam logic KIND_HEIGHT = 1'b0;
    localparam logic KIND_NORMAL = 1'b1;

    // register indexes
    localparam logic [2:0] REG_NUM_ROWS     = 3'd0;
    localparam logic [2:0] REG_NUM_COLS     = 3'd1;
    localparam logic [2:0] REG_HALF_X       = 3'd2;
    localparam logic [2:0] REG_HALF_Y       = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd4;
    localparam logic [2:0] REG_INV_DX       = 3'd5;
    localparam logic [2:0] REG_INV_DY       = 3'd6;

    // register reset values
    localparam logic [8:0]  RST_NUM_ROWS     = 9'd256;
    localparam logic [8:0]  RST_NUM_COLS     = 9'd256;
    localparam logic [30:0] RST_HALF_X       = 31'd65536;
    localparam logic [30:0] RST_HALF_Y       = 31'd65536;
    localparam logic [30:0] RST_HEIGHT_SCALE = 31'd65536;
    localparam logic [30:0] RST_INV_DX       = 31'd8355840;
    localparam logic [30:0] RST_INV_DY       = 31'd8355840;

    // unit normal z in Q2.14
    localparam logic [15:0] NORM_ONE = 16'd16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_WGT,
        ST_HACC,
        ST_HSCL,
        ST_KMUL,
        ST_NRD,
        ST_NSLP,
        ST_NSQ,
        ST_FSQ,
        ST_SQRT,
        ST_DSET,
        ST_DIV,
        ST_NBLD,
        ST_OUT
    } t_state;

endpackage

/* src/hbs_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/heightfield_bilinear_sampler.sv */
// Heightfield bilinear sampler: sample store, height and normal queries.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser func, tdata positions,
//            |           |                               | load address and sample
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tuser kind, tdata height and
//            |           |                               | normal components
//  cfg       | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  A load writes the sample store and gives no result. In a normal query, the
//  four corners each run one 32-step square-root pass through one bit-serial root
//  unit and three divides through one 17-step divider, then a final root and three
//  divides follow unless that root is zero. All multiplies share one 33x32 multiplier.
//  One item is in work at a time; s_axis_tready is high only while idle.
//  Reset is synchronous, active low; it restores the configuration and control registers. The sample store
//  is not cleared and reads of unwritten samples are undefined.
//  A finished result waits in the output register; the next item is taken meanwhile,
//  and a query stalls only at its end if the previous result is still held.

module heightfield_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] x_pos, [63:32] y_pos, [79:64] load_addr, [95:80] load_value
    input  logic [95:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] height_out, [47:32] normal_x, [63:48] normal_y, [79:64] normal_z
    output logic [79:0] m_axis_tdata,
    // [0] kind
    output logic        m_axis_tuser,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    localparam int RIDX_W = $clog2(MAX_ROWS);
    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);

    // configuration registers
    logic [8:0]  r_num_rows, r_num_cols;
    logic [30:0] r_half_x, r_half_y, r_height_scale, r_inv_dx, r_inv_dy;

    // control
    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [1:0]  r_corner, n_corner;
    logic [1:0]  r_comp, n_comp;
    logic        r_final, n_final;

    // query data
    logic signed [31:0] r_x, r_y;
    logic               r_is_norm;
    logic [15:0]        r_tx, r_ty;
    logic [CIDX_W-1:0]  r_x0, r_x1;
    logic [RIDX_W-1:0]  r_y0, r_y1;
    logic [32:0]        r_w [4];
    logic [48:0]        r_hsum;
    logic [31:0]        r_height;
    logic [45:0]        r_kx, r_ky;
    logic [15:0]        r_smp [4];
    logic [47:0]        r_plo;
    logic [30:0]        r_gmag [2];
    logic [1:0]         r_gneg;
    logic [63:0]        r_q;
    logic [63:0]        r_root;
    logic [31:0]        r_drem;
    logic [16:0]        r_dlow;
    logic               r_dneg;
    logic [16:0]        r_vn_mag [3];
    logic [2:0]         r_vn_neg;
    logic signed [49:0] r_acc [3];
    logic [15:0]        r_nout [3];

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_full;
    logic [63:0] r_prod;

    // output register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [79:0] r_out_data;

    logic        in_acc;
    logic [1:0]  in_func;
    logic [1:0]  cm1;

    logic [RDIM_W-1:0] eff_rows;
    logic [CDIM_W-1:0] eff_cols;

    // sample store
    logic                  ram_we;
    logic [STORE_AW-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;

    function automatic logic [STORE_AW-1:0] f_addr(
        input logic [RIDX_W-1:0] row,
        input logic [CIDX_W-1:0] col,
        input logic [CDIM_W-1:0] cols
    );
        logic [31:0] lin;
        lin = 32'(row) * 32'(cols) + 32'(col);
        return lin[STORE_AW-1:0];
    endfunction

    // |d|*k rounded, ties away; central differences halve it
    function automatic logic [30:0] f_slope(
        input logic [47:0] plo,
        input logic [63:0] phi,
        input logic        central
    );
        logic [63:0] p;
        logic [63:0] rnd;
        logic [63:0] sh;
        p   = 64'(plo) + {phi[31:0], 32'b0};
        rnd = p + (central ? 64'd65536 : 64'd32768);
        sh  = central ? (rnd >> 17) : (rnd >> 16);
        return (sh > 64'd2147483647) ? 31'h7FFF_FFFF : sh[30:0];
    endfunction

    assign in_func       = s_axis_tuser;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cm1           = 2'(r_cnt - 5'd1);

    assign ram_we = in_acc && (in_func == FUNC_LOAD);

    hbs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[79:64]),
        .i_wdata (s_axis_tdata[95:80]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // grid size clamped to [2, MAX]
    always_comb begin
        if (r_num_rows < 9'd2) begin
            eff_rows = RDIM_W'(2);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            eff_rows = RDIM_W'(MAX_ROWS);
        end else begin
            eff_rows = RDIM_W'(r_num_rows);
        end
        if (r_num_cols < 9'd2) begin
            eff_cols = CDIM_W'(2);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            eff_cols = CDIM_W'(MAX_COLS);
        end else begin
            eff_cols = CDIM_W'(r_num_cols);
        end
    end

    // ---- grid mapping: (pos + half) magnitude and sign
    logic [32:0] sx, sy;
    logic [31:0] mag_x, mag_y;
    assign sx    = {r_x[31], r_x} + {2'b0, r_half_x};
    assign sy    = {r_y[31], r_y} + {2'b0, r_half_y};
    assign mag_x = sx[32] ? 32'(-sx) : sx[31:0];
    assign mag_y = sy[32] ? 32'(-sy) : sy[31:0];

    // axis result from the product in r_prod (x at count 1, y at count 2)
    logic        ax_neg_nz;
    logic [31:0] ax_nm1, ax_fl, ax_i0, ax_i1, ax_wlo;
    always_comb begin
        ax_neg_nz = ((r_cnt == 5'd1) ? sx[32] : sy[32]) && (r_prod != 64'd0);
        ax_nm1    = (r_cnt == 5'd1) ? 32'(eff_cols) - 32'd1 : 32'(eff_rows) - 32'd1;
        ax_fl     = {1'b0, r_prod[62:32]};
        ax_wlo    = ax_neg_nz ? 32'(-r_prod[31:0]) : r_prod[31:0];
        if (ax_neg_nz) begin
            ax_i0 = 32'd0;
            ax_i1 = 32'd0;
        end else begin
            ax_i0 = (ax_fl > ax_nm1) ? ax_nm1 : ax_fl;
            ax_i1 = (ax_fl + 32'd1 > ax_nm1) ? ax_nm1 : ax_fl + 32'd1;
        end
    end

    logic [16:0] a_x, a_y;
    assign a_x = 17'd65536 - 17'(r_tx);
    assign a_y = 17'd65536 - 17'(r_ty);

    // ---- corner geometry and neighbour indices
    logic [1:0]        sel;
    logic [RIDX_W-1:0] crow, ra, rb, rows_m1;
    logic [CIDX_W-1:0] ccol, ca, cb, cols_m1;
    logic              cen_x, cen_y;
    always_comb begin
        sel     = (r_state == ST_HACC) ? r_cnt[1:0] : r_corner;
        crow    = sel[1] ? r_y1 : r_y0;
        ccol    = sel[0] ? r_x1 : r_x0;
        cols_m1 = CIDX_W'(eff_cols - 1'b1);
        rows_m1 = RIDX_W'(eff_rows - 1'b1);
        if (ccol == '0) begin
            ca = CIDX_W'(1); cb = '0; cen_x = 1'b0;
        end else if (ccol == cols_m1) begin
            ca = cols_m1; cb = CIDX_W'(cols_m1 - 1'b1); cen_x = 1'b0;
        end else begin
            ca = CIDX_W'(ccol + 1'b1); cb = CIDX_W'(ccol - 1'b1); cen_x = 1'b1;
        end
        if (crow == '0) begin
            ra = RIDX_W'(1); rb = '0; cen_y = 1'b0;
        end else if (crow == rows_m1) begin
            ra = rows_m1; rb = RIDX_W'(rows_m1 - 1'b1); cen_y = 1'b0;
        end else begin
            ra = RIDX_W'(crow + 1'b1); rb = RIDX_W'(crow - 1'b1); cen_y = 1'b1;
        end
    end

    always_comb begin
        ram_raddr = f_addr(crow, ccol, eff_cols);
        if (r_state == ST_NRD) begin
            unique case (r_cnt[1:0])
                2'd0:    ram_raddr = f_addr(crow, ca, eff_cols);
                2'd1:    ram_raddr = f_addr(crow, cb, eff_cols);
                2'd2:    ram_raddr = f_addr(ra, ccol, eff_cols);
                default: ram_raddr = f_addr(rb, ccol, eff_cols);
            endcase
        end
    end

    // sample differences
    logic [16:0] dx, dy;
    logic [15:0] adx, ady;
    assign dx  = {1'b0, r_smp[0]} - {1'b0, r_smp[1]};
    assign dy  = {1'b0, r_smp[2]} - {1'b0, r_smp[3]};
    assign adx = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady = dy[16] ? 16'(-dy) : dy[15:0];

    // blended components cut by 18 bits, sign kept
    logic [30:0] c_mag [3];
    logic [2:0]  c_neg;
    logic [49:0] acc_abs [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_neg[j]   = r_acc[j][49];
            acc_abs[j] = r_acc[j][49] ? 50'(-r_acc[j]) : 50'(r_acc[j]);
            c_mag[j]   = acc_abs[j][48:18];
        end
    end

    // ---- shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MAP: begin
                if (r_cnt == 5'd0) begin
                    mul_a = 33'(mag_x); mul_b = 32'(r_inv_dx);
                end else begin
                    mul_a = 33'(mag_y); mul_b = 32'(r_inv_dy);
                end
            end
            ST_WGT: begin
                unique case (r_cnt[1:0])
                    2'd0:    begin mul_a = 33'(a_x);  mul_b = 32'(a_y);  end
                    2'd1:    begin mul_a = 33'(r_tx); mul_b = 32'(a_y);  end
                    2'd2:    begin mul_a = 33'(a_x);  mul_b = 32'(r_ty); end
                    default: begin mul_a = 33'(r_tx); mul_b = 32'(r_ty); end
                endcase
            end
            ST_HACC: begin
                mul_a = r_w[cm1];
                mul_b = 32'(ram_rdata);
            end
            ST_HSCL: begin
                mul_a = r_hsum[48:16];
                mul_b = 32'(r_height_scale);
            end
            ST_KMUL: begin
                mul_a = 33'(r_height_scale);
                mul_b = (r_cnt == 5'd0) ? 32'(r_inv_dx) : 32'(r_inv_dy);
            end
            ST_NSLP: begin
                unique case (r_cnt[1:0])
                    2'd0:    begin mul_a = 33'(r_kx[31:0]);  mul_b = 32'(adx); end
                    2'd1:    begin mul_a = 33'(r_kx[45:32]); mul_b = 32'(adx); end
                    2'd2:    begin mul_a = 33'(r_ky[31:0]);  mul_b = 32'(ady); end
                    default: begin mul_a = 33'(r_ky[45:32]); mul_b = 32'(ady); end
                endcase
            end
            ST_NSQ: begin
                mul_a = 33'(r_gmag[r_cnt[0]]);
                mul_b = 32'(r_gmag[r_cnt[0]]);
            end
            ST_FSQ: begin
                if (r_cnt < 5'd3) begin
                    mul_a = 33'(c_mag[r_cnt[1:0]]);
                    mul_b = 32'(c_mag[r_cnt[1:0]]);
                end
            end
            ST_NBLD: begin
                if (r_cnt < 5'd3) begin
                    mul_a = r_w[r_corner];
                    mul_b = 32'(r_vn_mag[r_cnt[1:0]]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = 65'(mul_a) * 65'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[63:0];
    end

    // ---- square root step (one result bit per cycle)
    logic [5:0]  sq_sh;
    logic [63:0] sq_bit;
    logic [64:0] sq_trial;
    logic        sq_ge;
    assign sq_sh    = {~r_cnt, 1'b0};
    assign sq_bit   = 64'd1 << sq_sh;
    assign sq_trial = {1'b0, r_root} + {1'b0, sq_bit};
    assign sq_ge    = ({1'b0, r_q} >= sq_trial);

    // ---- divider set-up and step
    logic [47:0] dv_mag;
    logic        dv_neg;
    logic [48:0] dv_num;
    always_comb begin
        if (r_final) begin
            dv_mag = {3'b0, c_mag[r_comp], 14'b0};
            dv_neg = c_neg[r_comp];
        end else if (r_comp == 2'd2) begin
            dv_mag = 48'h1_0000_0000;
            dv_neg = 1'b0;
        end else begin
            dv_mag = {1'b0, r_gmag[r_comp[0]], 16'b0};
            dv_neg = !r_gneg[r_comp[0]];
        end
        dv_num = 49'(dv_mag) + 49'(r_root[31:1]);
    end

    logic [32:0] dv_trial;
    logic        dv_ge;
    logic [31:0] dv_rem;
    logic [16:0] dv_quo;
    assign dv_trial = {r_drem, r_dlow[16]};
    assign dv_ge    = (dv_trial >= {1'b0, r_root[31:0]});
    assign dv_rem   = dv_ge ? 32'(dv_trial - {1'b0, r_root[31:0]}) : dv_trial[31:0];
    assign dv_quo   = {r_dlow[15:0], dv_ge};

    // ---- next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt + 5'd1;
        n_corner = r_corner;
        n_comp   = r_comp;
        n_final  = r_final;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc && (in_func == FUNC_HEIGHT || in_func == FUNC_NORMAL)) begin
                    n_state  = ST_MAP;
                    n_final  = 1'b0;
                    n_corner = '0;
                end
            end
            ST_MAP: begin
                if (r_cnt == 5'd2) begin
                    n_state = ST_WGT;
                    n_cnt   = '0;
                end
            end
            ST_WGT: begin
                if (r_cnt == 5'd4) begin
                    n_state = r_is_norm ? ST_KMUL : ST_HACC;
                    n_cnt   = '0;
                end
            end
            ST_HACC: begin
                if (r_cnt == 5'd5) begin
                    n_state = ST_HSCL;
                    n_cnt   = '0;
                end
            end
            ST_HSCL: begin
                if (r_cnt == 5'd1) begin
                    n_state = ST_OUT;
                end
            end
            ST_KMUL: begin
                if (r_cnt == 5'd2) begin
                    n_state  = ST_NRD;
                    n_cnt    = '0;
                    n_corner = '0;
                end
            end
            ST_NRD: begin
                if (r_cnt == 5'd4) begin
                    n_state = ST_NSLP;
                    n_cnt   = '0;
                end
            end
            ST_NSLP: begin
                if (r_cnt == 5'd4) begin
                    n_state = ST_NSQ;
                    n_cnt   = '0;
                end
            end
            ST_NSQ: begin
                if (r_cnt == 5'd2) begin
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                end
            end
            ST_FSQ: begin
                if (r_cnt == 5'd3) begin
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                end
            end
            ST_SQRT: begin
                if (r_cnt == 5'd31) begin
                    n_state = ST_DSET;
                    n_comp  = '0;
                end
            end
            ST_DSET: begin
                n_cnt   = '0;
                n_state = (r_final && r_root == 64'd0) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 5'd16) begin
                    n_cnt = '0;
                    if (r_comp == 2'd2) begin
                        n_state = r_final ? ST_OUT : ST_NBLD;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = ST_DSET;
                    end
                end
            end
            ST_NBLD: begin
                if (r_cnt == 5'd3) begin
                    n_cnt = '0;
                    if (r_corner == 2'd3) begin
                        n_state = ST_FSQ;
                        n_final = 1'b1;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_state  = ST_NRD;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_corner <= '0;
            r_comp   <= '0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
            r_comp   <= n_comp;
            r_final  <= n_final;
        end
    end

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows     <= RST_NUM_ROWS;
            r_num_cols     <= RST_NUM_COLS;
            r_half_x       <= RST_HALF_X;
            r_half_y       <= RST_HALF_Y;
            r_height_scale <= RST_HEIGHT_SCALE;
            r_inv_dx       <= RST_INV_DX;
            r_inv_dy       <= RST_INV_DY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NUM_ROWS:     r_num_rows     <= i_cfg_data[8:0];
                REG_NUM_COLS:     r_num_cols     <= i_cfg_data[8:0];
                REG_HALF_X:       r_half_x       <= i_cfg_data;
                REG_HALF_Y:       r_half_y       <= i_cfg_data;
                REG_HEIGHT_SCALE: r_height_scale <= i_cfg_data;
                REG_INV_DX:       r_inv_dx       <= i_cfg_data;
                REG_INV_DY:       r_inv_dy       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_x       <= s_axis_tdata[31:0];
                    r_y       <= s_axis_tdata[63:32];
                    r_is_norm <= (in_func == FUNC_NORMAL);
                end
            end
            ST_MAP: begin
                if (r_cnt == 5'd1) begin
                    r_tx <= ax_wlo[31:16];
                    r_x0 <= CIDX_W'(ax_i0);
                    r_x1 <= CIDX_W'(ax_i1);
                end else if (r_cnt == 5'd2) begin
                    r_ty <= ax_wlo[31:16];
                    r_y0 <= RIDX_W'(ax_i0);
                    r_y1 <= RIDX_W'(ax_i1);
                end
            end
            ST_WGT: begin
                r_hsum <= '0;
                if (r_cnt != 5'd0) begin
                    r_w[cm1] <= r_prod[32:0];
                end
            end
            ST_HACC: begin
                if (r_cnt >= 5'd2) begin
                    r_hsum <= r_hsum + r_prod[48:0];
                end
            end
            ST_HSCL: begin
                if (r_cnt == 5'd1) begin
                    r_height <= 32'((r_prod + 64'h8000_0000) >> 32);
                end
            end
            ST_KMUL: begin
                if (r_cnt == 5'd1) begin
                    r_kx <= r_prod[61:16];
                end else if (r_cnt == 5'd2) begin
                    r_ky <= r_prod[61:16];
                end
                for (int j = 0; j < 3; j++) begin
                    r_acc[j] <= '0;
                end
            end
            ST_NRD: begin
                if (r_cnt != 5'd0) begin
                    r_smp[cm1] <= ram_rdata;
                end
            end
            ST_NSLP: begin
                if (r_cnt == 5'd1 || r_cnt == 5'd3) begin
                    r_plo <= r_prod[47:0];
                end else if (r_cnt == 5'd2) begin
                    r_gmag[0] <= f_slope(r_plo, r_prod, cen_x);
                    r_gneg[0] <= dx[16];
                end else if (r_cnt == 5'd4) begin
                    r_gmag[1] <= f_slope(r_plo, r_prod, cen_y);
                    r_gneg[1] <= dy[16];
                end
            end
            ST_NSQ: begin
                r_root <= '0;
                if (r_cnt == 5'd1) begin
                    r_q <= r_prod + 64'h1_0000_0000;
                end else if (r_cnt == 5'd2) begin
                    r_q <= r_q + r_prod;
                end
            end
            ST_FSQ: begin
                r_root <= '0;
                if (r_cnt == 5'd1) begin
                    r_q <= r_prod;
                end else if (r_cnt != 5'd0) begin
                    r_q <= r_q + r_prod;
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_q    <= 64'(65'(r_q) - sq_trial);
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            ST_DSET: begin
                r_drem <= dv_num[48:17];
                r_dlow <= dv_num[16:0];
                r_dneg <= dv_neg;
                if (r_final && r_root == 64'd0) begin
                    r_nout[0] <= '0;
                    r_nout[1] <= '0;
                    r_nout[2] <= NORM_ONE;
                end
            end
            ST_DIV: begin
                r_drem <= dv_rem;
                r_dlow <= dv_quo;
                if (r_cnt == 5'd16) begin
                    if (r_final) begin
                        r_nout[r_comp] <= r_dneg ? 16'(-dv_quo) : dv_quo[15:0];
                    end else begin
                        r_vn_mag[r_comp] <= dv_quo;
                        r_vn_neg[r_comp] <= r_dneg;
                    end
                end
            end
            ST_NBLD: begin
                if (r_cnt != 5'd0) begin
                    if (r_vn_neg[cm1]) begin
                        r_acc[cm1] <= r_acc[cm1] - $signed({1'b0, r_prod[48:0]});
                    end else begin
                        r_acc[cm1] <= r_acc[cm1] + $signed({1'b0, r_prod[48:0]});
                    end
                end
            end
            default: ;
        endcase
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            if (r_is_norm) begin
                r_out_kind <= KIND_NORMAL;
                r_out_data <= {r_nout[2], r_nout[1], r_nout[0], 32'b0};
            end else begin
                r_out_kind <= KIND_HEIGHT;
                r_out_data <= {48'b0, r_height};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule
